// ===== rtl/protobuf_fixed64_field_extractor_macros.svh =====
// Assertion macros shared by the extractor RTL.
// Each macro places one labeled concurrent assertion on the rising clock edge,
// disabled while the synchronous reset is asserted.
`ifndef PROTOBUF_FIXED64_FIELD_EXTRACTOR_MACROS_SVH
`define PROTOBUF_FIXED64_FIELD_EXTRACTOR_MACROS_SVH

`ifndef SYNTH

`define PFX_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("extractor implication check failed");

`define PFX_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("extractor forbidden condition seen");

`else

`define PFX_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define PFX_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/pfx_pkg.sv =====
// ----------------------------------------------------------------------------
// pfx_pkg
// Types and constants of the protobuf fixed64 field extractor.
// ----------------------------------------------------------------------------
package pfx_pkg;

  localparam int OUT_DEPTH_DEF = 4;

  localparam int TARGET_W     = 29;
  localparam int TARGET_RESET = 1;
  localparam int VARINT_MAX   = 10;

  // Register indexes on the configuration port.
  localparam logic REG_TARGET = 1'b0;

  // Wire types.
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // Result kinds.
  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAN    = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_BADWIRE  = 2'd2,
    ST_OVERLONG = 2'd3
  } end_status_t;

  typedef enum logic [1:0] {
    PH_KEY,
    PH_VARINT,
    PH_LENGTH,
    PH_BYTES
  } phase_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       final_byte;
  } in_data_t;

  typedef struct packed {
    logic        result_kind;
    logic [63:0] field_value;
    logic [1:0]  end_status;
    logic        last_of_run;
  } out_data_t;

  // Results produced by one parsed byte: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    out_data_t  first;
    out_data_t  second;
  } push_t;

  typedef struct packed {
    logic has_room;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/pfx_parser.sv =====
// ----------------------------------------------------------------------------
// pfx_parser
// Input register and wire format parser; one byte is parsed per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module pfx_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pfx_pkg::in_data_t             in_data,
  input  logic [pfx_pkg::TARGET_W-1:0]  target_field,
  input  pfx_pkg::fifo_stat_t           stat,
  output pfx_pkg::push_t                push
);
  import pfx_pkg::*;

  logic        in_valid_r;
  in_data_t    in_data_r;
  logic        advance;

  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        match_r, match_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        stop_r, stop_nxt;
  logic [1:0]  reason_r, reason_nxt;

  logic [7:0]  b;
  logic [63:0] vbits;
  logic [63:0] vacc;
  logic [3:0]  vcnt;
  logic        vdone;
  logic        vover;
  logic [2:0]  bslot;
  logic [63:0] bacc;
  logic [31:0] rem_dec;
  logic [31:0] fnum;
  logic        emit_val;
  logic [63:0] emit_data;
  logic [1:0]  end_st;

  assign advance  = in_valid_r && stat.has_room;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_KEY;
      acc_r    <= '0;
      cnt_r    <= '0;
      match_r  <= 1'b0;
      rem_r    <= '0;
      stop_r   <= 1'b0;
      reason_r <= ST_CLEAN;
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      match_r  <= match_nxt;
      rem_r    <= rem_nxt;
      stop_r   <= stop_nxt;
      reason_r <= reason_nxt;
    end
  end

  // Varint byte: seven payload bits land at 7 * byte count; bits past 63 drop.
  assign b     = in_data_r.msg_byte;
  assign vbits = (cnt_r < 4'(VARINT_MAX)) ?
                 (64'(b[6:0]) << (6'(cnt_r) * 6'd7)) : 64'd0;
  assign vacc  = acc_r | vbits;
  assign vcnt  = cnt_r + 4'd1;
  assign vdone = !b[7];
  assign vover = b[7] && (vcnt >= 4'(VARINT_MAX));
  assign fnum  = vacc[34:3];

  // Fixed64 payload byte: the slot is (8 - remaining) mod 8.
  assign bslot   = 3'd0 - rem_r[2:0];
  assign bacc    = acc_r | (64'(b) << {bslot, 3'b000});
  assign rem_dec = (rem_r != 32'd0) ? rem_r - 32'd1 : 32'd0;

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    match_nxt  = match_r;
    rem_nxt    = rem_r;
    stop_nxt   = stop_r;
    reason_nxt = reason_r;
    emit_val   = 1'b0;
    emit_data  = bacc;
    end_st     = ST_CLEAN;

    if (advance && !stop_r) begin
      case (phase_r)
        PH_BYTES: begin
          if (match_r) begin
            acc_nxt = bacc;
          end
          rem_nxt = rem_dec;
          if (rem_dec == 32'd0) begin
            emit_val  = match_r;
            acc_nxt   = '0;
            match_nxt = 1'b0;
            phase_nxt = PH_KEY;
          end
        end
        PH_VARINT, PH_LENGTH, PH_KEY: begin
          acc_nxt = vacc;
          cnt_nxt = vcnt;
          if (vdone) begin
            acc_nxt = '0;
            cnt_nxt = '0;
            if (phase_r == PH_VARINT) begin
              phase_nxt = PH_KEY;
            end else if (phase_r == PH_LENGTH) begin
              if (vacc[63:32] != 32'd0) begin
                stop_nxt   = 1'b1;
                reason_nxt = ST_TRUNC;
              end else if (vacc[31:0] == 32'd0) begin
                phase_nxt = PH_KEY;
              end else begin
                rem_nxt   = vacc[31:0];
                match_nxt = 1'b0;
                phase_nxt = PH_BYTES;
              end
            end else begin
              case (vacc[2:0])
                WT_VARINT: begin
                  phase_nxt = PH_VARINT;
                end
                WT_FIXED64: begin
                  rem_nxt   = 32'd8;
                  match_nxt = (fnum == 32'(target_field));
                  phase_nxt = PH_BYTES;
                end
                WT_LEN: begin
                  phase_nxt = PH_LENGTH;
                end
                WT_FIXED32: begin
                  rem_nxt   = 32'd4;
                  match_nxt = 1'b0;
                  phase_nxt = PH_BYTES;
                end
                default: begin
                  stop_nxt   = 1'b1;
                  reason_nxt = ST_BADWIRE;
                end
              endcase
            end
          end else if (vover) begin
            stop_nxt   = 1'b1;
            reason_nxt = ST_OVERLONG;
          end
        end
        default: begin
          phase_nxt = PH_KEY;
        end
      endcase
    end

    // The last byte reports how the message ended and rearms the parser.
    if (advance && in_data_r.final_byte) begin
      if (stop_nxt) begin
        end_st = reason_nxt;
      end else if (phase_nxt == PH_KEY && cnt_nxt == 4'd0) begin
        end_st = ST_CLEAN;
      end else begin
        end_st = ST_TRUNC;
      end
      phase_nxt  = PH_KEY;
      acc_nxt    = '0;
      cnt_nxt    = '0;
      match_nxt  = 1'b0;
      rem_nxt    = '0;
      stop_nxt   = 1'b0;
      reason_nxt = ST_CLEAN;
    end
  end

  always_comb begin
    out_data_t val_res;
    out_data_t end_res;
    val_res.result_kind = KIND_VALUE;
    val_res.field_value = emit_data;
    val_res.end_status  = ST_CLEAN;
    val_res.last_of_run = !in_data_r.final_byte;
    end_res.result_kind = KIND_END;
    end_res.field_value = '0;
    end_res.end_status  = end_st;
    end_res.last_of_run = 1'b1;

    push.count  = 2'(emit_val) + 2'(advance && in_data_r.final_byte);
    push.first  = emit_val ? val_res : end_res;
    push.second = end_res;
  end

endmodule

// ===== rtl/pfx_out_fifo.sv =====
// ----------------------------------------------------------------------------
// pfx_out_fifo
// Result queue that takes up to two results a cycle and gives one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module pfx_out_fifo #(
  parameter int DEPTH = pfx_pkg::OUT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfx_pkg::push_t       push,
  output pfx_pkg::fifo_stat_t  stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pfx_pkg::out_data_t   out_data
);
  import pfx_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_data_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_next;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign pop       = out_valid && out_ready;
  assign wr_next   = ptr_inc(wr_ptr_r);
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_ptr_r];

  // Room for the largest burst one byte can cause.
  assign stat.has_room = (cnt_r <= CNT_W'(DEPTH - 2));
  assign stat.empty    = (cnt_r == '0);

  always_comb begin
    case (push.count)
      2'd1:    wr_ptr_nxt = wr_next;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_next);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_next] <= push.second;
    end
  end

endmodule

// ===== rtl/protobuf_fixed64_field_extractor.sv =====
// A byte is taken into the input register and parsed from there; its results are
// written into the result queue, from which they are offered on out_data.
// Throughput: one byte per cycle, paced by the result queue, which drains one
// result per cycle while out_ready is high; a last byte that also closes a
// matching fixed64 field yields two results. Reset is synchronous: the parser
// returns to reading a key, the queue empties and target_field returns to 1.
// ----------------------------------------------------------------------------
// protobuf_fixed64_field_extractor
// Streaming protobuf parser that extracts fixed64 values of one field number.
// ----------------------------------------------------------------------------
`include "protobuf_fixed64_field_extractor_macros.svh"

module protobuf_fixed64_field_extractor #(
  parameter int OUT_DEPTH = pfx_pkg::OUT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfx_pkg::in_data_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pfx_pkg::out_data_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pfx_pkg::*;

  logic [TARGET_W-1:0] target_r;
  push_t               push;
  fifo_stat_t          stat;
  logic                reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TARGET);
  assign prdata = (paddr[2] == REG_TARGET) ? 32'(target_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_W'(TARGET_RESET);
    end else if (reg_wr) begin
      target_r <= pwdata[TARGET_W-1:0];
    end
  end

  pfx_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .target_field (target_r),
    .stat         (stat),
    .push         (push)
  );

  pfx_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The parser only produces results when the queue can hold a full burst.
  `PFX_ASSERT_IMPLY(a_push_room, clk, rst_n, push.count != 2'd0, stat.has_room)
  `PFX_ASSERT_NEVER(a_push_count, clk, rst_n, push.count == 2'd3)
  // A pair is always a value followed by the end report that closes the run.
  `PFX_ASSERT_IMPLY(a_pair_order, clk, rst_n, push.count == 2'd2,
    push.first.result_kind == KIND_VALUE && !push.first.last_of_run &&
    push.second.result_kind == KIND_END && push.second.last_of_run)
  `PFX_ASSERT_IMPLY(a_end_form, clk, rst_n,
    push.count != 2'd0 && push.first.result_kind == KIND_END,
    push.first.field_value == 64'd0 && push.first.last_of_run)

endmodule
